[rtl/core/sra_pkg.sv]
// Shared types and constants for the streaming substring replace unit.
// No dependencies.
package sra_pkg;

  localparam int unsigned SEARCH_MAX = 8;
  localparam int unsigned REPLACE_MAX = 8;
  localparam int unsigned CHAR_W = 16;
  localparam int unsigned CNT_W = 4;
  localparam int unsigned IDX_W = 3;

  localparam logic [2:0] REG_SEARCH_LO  = 3'd0;
  localparam logic [2:0] REG_SEARCH_HI  = 3'd1;
  localparam logic [2:0] REG_REPLACE_LO = 3'd2;
  localparam logic [2:0] REG_REPLACE_HI = 3'd3;
  localparam logic [2:0] REG_SEARCH_LEN = 3'd4;
  localparam logic [2:0] REG_REPL_LEN   = 3'd5;
  localparam logic [2:0] REG_WIDE       = 3'd6;

  typedef struct packed {
    logic load;
    logic shift;
  } cell_ctrl_t;

  typedef struct packed {
    logic [127:0]       search;
    logic [127:0]       replace;
    logic [CNT_W-1:0]   slen;
    logic [CNT_W-1:0]   rlen;
    logic               wide;
  } cfg_t;

endpackage

[rtl/core/sra_cell.sv]
// One pending-character cell: holds a character, loads or shifts from its
// neighbor, compares against its search character. Uses sra_pkg.
module sra_cell (
  input  logic                         clk_i,
  input  sra_pkg::cell_ctrl_t          ctrl_i,
  input  logic [sra_pkg::CHAR_W-1:0]   load_char_i,
  input  logic [sra_pkg::CHAR_W-1:0]   next_char_i,
  input  logic [sra_pkg::CHAR_W-1:0]   search_char_i,
  input  logic [sra_pkg::CHAR_W-1:0]   mask_i,
  output logic [sra_pkg::CHAR_W-1:0]   char_o,
  output logic                         match_o
);

  logic [sra_pkg::CHAR_W-1:0] char_q, char_d;

  always_comb begin
    char_d = char_q;
    if (ctrl_i.load) begin
      char_d = load_char_i;
    end else if (ctrl_i.shift) begin
      char_d = next_char_i;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

  assign char_o  = char_q;
  assign match_o = ((char_q & mask_i) == (search_char_i & mask_i));

endmodule

[rtl/core/sra_cfg.sv]
// Configuration register file behind the APB-style port.
// Uses sra_pkg; flags writes that discard pending characters.
module sra_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel_i,
  input  logic          penable_i,
  input  logic          pwrite_i,
  input  logic [5:0]    paddr_i,
  input  logic [63:0]   pwdata_i,
  output logic [63:0]   prdata_o,
  output logic          pready_o,
  output sra_pkg::cfg_t cfg_o,
  output logic          clr_o
);

  logic [63:0] search_lo_q, search_hi_q, repl_lo_q, repl_hi_q;
  logic [3:0]  slen_q, rlen_q;
  logic        wide_q;
  logic        wr;
  logic [2:0]  idx;

  assign pready_o = 1'b1;
  assign wr  = psel_i & penable_i & pwrite_i;
  assign idx = paddr_i[5:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      search_lo_q <= '0;
      search_hi_q <= '0;
      repl_lo_q   <= '0;
      repl_hi_q   <= '0;
      slen_q      <= 4'd1;
      rlen_q      <= 4'd0;
      wide_q      <= 1'b1;
    end else if (wr) begin
      unique case (idx)
        sra_pkg::REG_SEARCH_LO:  search_lo_q <= pwdata_i;
        sra_pkg::REG_SEARCH_HI:  search_hi_q <= pwdata_i;
        sra_pkg::REG_REPLACE_LO: repl_lo_q   <= pwdata_i;
        sra_pkg::REG_REPLACE_HI: repl_hi_q   <= pwdata_i;
        sra_pkg::REG_SEARCH_LEN: slen_q      <= pwdata_i[3:0];
        sra_pkg::REG_REPL_LEN:   rlen_q      <= pwdata_i[3:0];
        sra_pkg::REG_WIDE:       wide_q      <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  assign clr_o = wr & ((idx == sra_pkg::REG_SEARCH_LO) || (idx == sra_pkg::REG_SEARCH_HI) ||
                       (idx == sra_pkg::REG_SEARCH_LEN) || (idx == sra_pkg::REG_WIDE));

  always_comb begin
    unique case (idx)
      sra_pkg::REG_SEARCH_LO:  prdata_o = search_lo_q;
      sra_pkg::REG_SEARCH_HI:  prdata_o = search_hi_q;
      sra_pkg::REG_REPLACE_LO: prdata_o = repl_lo_q;
      sra_pkg::REG_REPLACE_HI: prdata_o = repl_hi_q;
      sra_pkg::REG_SEARCH_LEN: prdata_o = {60'd0, slen_q};
      sra_pkg::REG_REPL_LEN:   prdata_o = {60'd0, rlen_q};
      sra_pkg::REG_WIDE:       prdata_o = {63'd0, wide_q};
      default:                 prdata_o = '0;
    endcase
  end

  always_comb begin
    cfg_o.search  = {search_hi_q, search_lo_q};
    cfg_o.replace = {repl_hi_q, repl_lo_q};
    cfg_o.wide    = wide_q;
    if (slen_q == 4'd0) begin
      cfg_o.slen = 4'd1;
    end else if (slen_q > 4'(sra_pkg::SEARCH_MAX)) begin
      cfg_o.slen = 4'(sra_pkg::SEARCH_MAX);
    end else begin
      cfg_o.slen = slen_q;
    end
    if (rlen_q > 4'(sra_pkg::REPLACE_MAX)) begin
      cfg_o.rlen = 4'(sra_pkg::REPLACE_MAX);
    end else begin
      cfg_o.rlen = rlen_q;
    end
  end

endmodule

[rtl/core/substring_replace_all_unit.sv]
// Top level of the streaming substring replace unit: sequencer, output
// register and the row of pending cells. Uses sra_pkg, sra_cfg, sra_cell.
//
// channel  | dir | tdata          | tuser      | tlast
// s_axis   | in  | char_in[15:0]  | -          | last_in
// m_axis   | out | char_out[15:0] | char_valid | end_of_text
// apb      | cfg | 64-bit regs at 8*i
//
// One request at a time: the next input character is accepted only once the
// sequencer has returned to idle after emitting its results.
// Emission is bounded by the single output register; a stalled m_axis
// holds the sequencer. Reset clears the pending count and sequencer.
module substring_replace_all_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // [15:0] char_in
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [15:0] char_out
  output logic        m_axis_tuser_o,   // [0] char_valid
  output logic        m_axis_tlast_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [5:0]  paddr_i,
  input  logic [63:0] pwdata_i,
  output logic [63:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned N = sra_pkg::SEARCH_MAX;
  localparam int unsigned W = sra_pkg::CHAR_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_REPL  = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_NULL  = 3'd4;

  sra_pkg::cfg_t cfg;
  logic          clr;

  sra_cfg u_cfg (
    .clk_i, .rst_ni, .psel_i, .penable_i, .pwrite_i, .paddr_i, .pwdata_i,
    .prdata_o, .pready_o, .cfg_o(cfg), .clr_o(clr)
  );

  logic [2:0]                  state_q, state_d;
  logic [sra_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [sra_pkg::IDX_W-1:0]   idx_q, idx_d;
  logic                        last_q, last_d;
  logic                        sent_q, sent_d;
  logic                        ovld_q, ovld_d;
  logic [W-1:0]                ochar_q, ochar_d;
  logic                        ouser_q, ouser_d;
  logic                        oend_q, oend_d;

  logic [W-1:0]  mask;
  logic [W-1:0]  cell_char [N];
  logic [N-1:0]  cell_match;
  logic          accept, slot, shift, prefix;
  sra_pkg::cell_ctrl_t ctrl [N];

  assign mask   = cfg.wide ? 16'hFFFF : 16'h00FF;
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign slot   = !ovld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE);

  for (genvar g = 0; g < N; g++) begin : g_cell
    logic [W-1:0] next_char;
    if (g == N - 1) begin : g_end
      assign next_char = '0;
    end else begin : g_mid
      assign next_char = cell_char[g+1];
    end
    assign ctrl[g].load  = accept && (cnt_q == sra_pkg::CNT_W'(g));
    assign ctrl[g].shift = shift;
    sra_cell u_cell (
      .clk_i,
      .ctrl_i(ctrl[g]),
      .load_char_i(s_axis_tdata_i & mask),
      .next_char_i(next_char),
      .search_char_i(cfg.search[g*W +: W]),
      .mask_i(mask),
      .char_o(cell_char[g]),
      .match_o(cell_match[g])
    );
  end

  always_comb begin
    prefix = 1'b1;
    for (int i = 0; i < N; i++) begin
      if ((sra_pkg::CNT_W'(i) < cnt_q) && !cell_match[i]) begin
        prefix = 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    last_d  = last_q;
    sent_d  = sent_q;
    shift   = 1'b0;
    ovld_d  = ovld_q & ~m_axis_tready_i;
    ochar_d = ochar_q;
    ouser_d = ouser_q;
    oend_d  = oend_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cnt_d   = cnt_q + 1'b1;
          last_d  = s_axis_tlast_i;
          sent_d  = 1'b0;
          state_d = S_SCAN;
        end else if (clr) begin
          cnt_d = '0;
        end
      end
      S_SCAN: begin
        if ((cnt_q == '0) || (prefix && (cnt_q != cfg.slen))) begin
          if (!last_q) begin
            state_d = S_IDLE;
          end else if (cnt_q != '0) begin
            state_d = S_FLUSH;
          end else if (!sent_q) begin
            state_d = S_NULL;
          end else begin
            state_d = S_IDLE;
          end
        end else if (prefix) begin
          cnt_d = '0;
          idx_d = '0;
          if (cfg.rlen != '0) begin
            state_d = S_REPL;
          end
        end else if (slot) begin
          ovld_d  = 1'b1;
          ochar_d = cell_char[0];
          ouser_d = 1'b1;
          oend_d  = last_q && (cnt_q == 4'd1);
          sent_d  = 1'b1;
          shift   = 1'b1;
          cnt_d   = cnt_q - 1'b1;
        end
      end
      S_REPL: begin
        if (slot) begin
          ovld_d  = 1'b1;
          ochar_d = cfg.replace[idx_q*W +: W] & mask;
          ouser_d = 1'b1;
          oend_d  = last_q && ({1'b0, idx_q} == cfg.rlen - 1'b1);
          sent_d  = 1'b1;
          idx_d   = idx_q + 1'b1;
          if ({1'b0, idx_q} == cfg.rlen - 1'b1) begin
            state_d = S_SCAN;
          end
        end
      end
      S_FLUSH: begin
        if (slot) begin
          ovld_d  = 1'b1;
          ochar_d = cell_char[0];
          ouser_d = 1'b1;
          oend_d  = (cnt_q == 4'd1);
          shift   = 1'b1;
          cnt_d   = cnt_q - 1'b1;
          if (cnt_q == 4'd1) begin
            state_d = S_IDLE;
          end
        end
      end
      S_NULL: begin
        if (slot) begin
          ovld_d  = 1'b1;
          ochar_d = '0;
          ouser_d = 1'b0;
          oend_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
      last_q  <= 1'b0;
      sent_q  <= 1'b0;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      last_q  <= last_d;
      sent_q  <= sent_d;
      ovld_q  <= ovld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ochar_q <= ochar_d;
    ouser_q <= ouser_d;
    oend_q  <= oend_d;
  end

  assign m_axis_tvalid_o = ovld_q;
  assign m_axis_tdata_o  = ochar_q;
  assign m_axis_tuser_o  = ouser_q;
  assign m_axis_tlast_o  = oend_q;

endmodule
